>>> rtl/core/qbs_pkg.sv
// ----------------------------------------------------------------------------
// qbs_pkg
// Shared constants and types for the quadratic Bezier sampler.
// ----------------------------------------------------------------------------
package qbs_pkg;

   localparam int SEG_BITS = 6;
   localparam int DSQ_BITS = 2 * SEG_BITS;
   localparam logic [SEG_BITS-1:0] SEG_RESET = 6'd39;

   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic done;
   } div_stat_type;

endpackage

>>> rtl/core/qbs_channels.sv
// ----------------------------------------------------------------------------
// qbs channels
// Valid/ready channels for control points, samples and the segment count.
// ----------------------------------------------------------------------------
interface qbs_req_if #(parameter int COORD_BITS = 12);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] p0_x;
   logic [COORD_BITS-1:0] p0_y;
   logic [COORD_BITS-1:0] p1_x;
   logic [COORD_BITS-1:0] p1_y;
   logic [COORD_BITS-1:0] p2_x;
   logic [COORD_BITS-1:0] p2_y;

   modport source (output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, input ready);
   modport sink   (input valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, output ready);
endinterface

interface qbs_rsp_if #(parameter int COORD_BITS = 12);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] sample_x;
   logic [COORD_BITS-1:0] sample_y;
   logic                  last_sample;

   modport source (output valid, sample_x, sample_y, last_sample, input ready);
   modport sink   (input valid, sample_x, sample_y, last_sample, output ready);
endinterface

interface qbs_csr_if;
   logic       valid;
   logic       ready;
   logic [5:0] segment_count;

   modport source (output valid, segment_count, input ready);
   modport sink   (input valid, segment_count, output ready);
endinterface

>>> rtl/core/qbs_divider.sv
// ----------------------------------------------------------------------------
// qbs_divider
// Restoring divider, one quotient bit per cycle; quotient fits COORD_BITS.
// ----------------------------------------------------------------------------
module qbs_divider #(
   parameter int COORD_BITS = 12
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  qbs_pkg::div_ctl_type                         ctl,
   input  logic [qbs_pkg::DSQ_BITS+COORD_BITS-1:0]      numerator,
   input  logic [qbs_pkg::DSQ_BITS-1:0]                 divisor,
   output qbs_pkg::div_stat_type                        stat,
   output logic [COORD_BITS-1:0]                        quotient
);
   import qbs_pkg::*;

   localparam int ZW = DSQ_BITS + COORD_BITS;
   localparam int CW = $clog2(COORD_BITS + 1);
   localparam logic [CW-1:0] LAST_STEP = CW'(COORD_BITS - 1);

   logic [ZW-1:0]       z_ff, z_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [ZW:0]         shifted;
   logic [DSQ_BITS:0]   hi;
   logic [DSQ_BITS:0]   hi_sub;
   logic                qbit;

   always_comb begin
      shifted = {z_ff, 1'b0};
      hi      = shifted[ZW:COORD_BITS];
      qbit    = (hi >= {1'b0, divisor});
      hi_sub  = qbit ? (hi - {1'b0, divisor}) : hi;
   end

   always_comb begin
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         z_in    = numerator;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         z_in   = {hi_sub[DSQ_BITS-1:0], shifted[COORD_BITS-1:1], qbit};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      z_ff <= z_in;
   end

   assign stat.done = done_ff;
   assign quotient  = z_ff[COORD_BITS-1:0];

endmodule

>>> rtl/core/quadratic_bezier_sampler.sv
// ----------------------------------------------------------------------------
// quadratic_bezier_sampler
// Emits N+1 floored samples of a quadratic Bezier segment per control triple.
// ----------------------------------------------------------------------------
// Each accepted item (P0, P1, P2) yields N+1 samples, k = 0..N, where N is
// the segment count register (0 is taken as 1). Per sample the S_WGT state
// forms the weights, one shared multiply-accumulate forms the x and y
// numerators in S_MAC, then one shared restoring divider divides each by
// N*N at one bit per cycle. A finished sample waits in S_OUT until the
// output takes it. req_ch.ready is high only while idle; csr_ch.ready is
// always high.
module quadratic_bezier_sampler #(
   parameter int COORD_BITS = 12
) (
   input  logic      clock,
   input  logic      reset,
   qbs_req_if.sink   req_ch,
   qbs_rsp_if.source rsp_ch,
   qbs_csr_if.sink   csr_ch
);
   import qbs_pkg::*;

   localparam int ZW = DSQ_BITS + COORD_BITS;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_WGT  = 3'd1;
   localparam logic [2:0] S_MAC  = 3'd2;
   localparam logic [2:0] S_DIVX = 3'd3;
   localparam logic [2:0] S_DIVY = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   localparam logic [2:0] SEL_LAST = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [SEG_BITS-1:0]   seg_ff, seg_in;
   logic [COORD_BITS-1:0] x0_ff, y0_ff, x1_ff, y1_ff, x2_ff, y2_ff;
   logic [SEG_BITS-1:0]   n_ff, n_in;
   logic [SEG_BITS-1:0]   k_ff, k_in;
   logic [DSQ_BITS-1:0]   dsq_ff, dsq_in;
   logic [DSQ_BITS-1:0]   w0_ff, w1_ff, w2_ff;
   logic [DSQ_BITS-1:0]   w0_in, w1_in, w2_in;
   logic [2:0]            sel_ff, sel_in;
   logic [ZW-1:0]         acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic [COORD_BITS-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic                  last_ff, last_in;

   logic [SEG_BITS-1:0]   r;
   logic [DSQ_BITS-1:0]   wsel;
   logic [COORD_BITS-1:0] csel;
   logic [ZW-1:0]         term;
   logic                  req_acc;
   logic                  rsp_acc;

   div_ctl_type           div_ctl;
   div_stat_type          div_stat;
   logic [ZW-1:0]         div_num;
   logic [COORD_BITS-1:0] div_q;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid = (state_ff == S_OUT);
   assign rsp_acc      = rsp_ch.valid && rsp_ch.ready;
   assign rsp_ch.sample_x    = sx_ff;
   assign rsp_ch.sample_y    = sy_ff;
   assign rsp_ch.last_sample = last_ff;
   assign csr_ch.ready = 1'b1;

   always_comb begin
      seg_in = seg_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         seg_in = csr_ch.segment_count;
      end
   end

   always_comb begin
      r     = n_ff - k_ff;
      w0_in = DSQ_BITS'(r * r);
      w1_in = DSQ_BITS'(r * k_ff) << 1;
      w2_in = DSQ_BITS'(k_ff * k_ff);
      dsq_in = DSQ_BITS'(n_ff * n_ff);
   end

   always_comb begin
      case (sel_ff)
         3'd0: begin wsel = w0_ff; csel = x0_ff; end
         3'd1: begin wsel = w1_ff; csel = x1_ff; end
         3'd2: begin wsel = w2_ff; csel = x2_ff; end
         3'd3: begin wsel = w0_ff; csel = y0_ff; end
         3'd4: begin wsel = w1_ff; csel = y1_ff; end
         3'd5: begin wsel = w2_ff; csel = y2_ff; end
         default: begin wsel = '0; csel = '0; end
      endcase
      term = ZW'(wsel * csel);
   end

   always_comb begin
      div_ctl.start = ((state_ff == S_MAC) && (sel_ff == SEL_LAST)) ||
                      ((state_ff == S_DIVX) && div_stat.done);
      div_num       = (state_ff == S_MAC) ? acc_x_ff : acc_y_ff;
   end

   qbs_divider #(
      .COORD_BITS (COORD_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .numerator (div_num),
      .divisor   (dsq_ff),
      .stat      (div_stat),
      .quotient  (div_q)
   );

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      k_in     = k_ff;
      sel_in   = sel_ff;
      acc_x_in = acc_x_ff;
      acc_y_in = acc_y_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      last_in  = last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               n_in     = (seg_ff == '0) ? SEG_BITS'(1) : seg_ff;
               k_in     = '0;
               state_in = S_WGT;
            end
         end
         S_WGT: begin
            acc_x_in = '0;
            acc_y_in = '0;
            sel_in   = '0;
            state_in = S_MAC;
         end
         S_MAC: begin
            if (sel_ff < 3'd3) begin
               acc_x_in = acc_x_ff + term;
            end else begin
               acc_y_in = acc_y_ff + term;
            end
            sel_in = sel_ff + 1'b1;
            if (sel_ff == SEL_LAST) begin
               state_in = S_DIVX;
            end
         end
         S_DIVX: begin
            if (div_stat.done) begin
               sx_in    = div_q;
               state_in = S_DIVY;
            end
         end
         S_DIVY: begin
            if (div_stat.done) begin
               sy_in    = div_q;
               last_in  = (k_ff == n_ff);
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_acc) begin
               if (last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_WGT;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         seg_ff   <= SEG_RESET;
      end else begin
         state_ff <= state_in;
         seg_ff   <= seg_in;
      end
      if (req_acc) begin
         x0_ff <= req_ch.p0_x;
         y0_ff <= req_ch.p0_y;
         x1_ff <= req_ch.p1_x;
         y1_ff <= req_ch.p1_y;
         x2_ff <= req_ch.p2_x;
         y2_ff <= req_ch.p2_y;
      end
      if (state_ff == S_WGT) begin
         w0_ff  <= w0_in;
         w1_ff  <= w1_in;
         w2_ff  <= w2_in;
         dsq_ff <= dsq_in;
      end
      n_ff     <= n_in;
      k_ff     <= k_in;
      sel_ff   <= sel_in;
      acc_x_ff <= acc_x_in;
      acc_y_ff <= acc_y_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      last_ff  <= last_in;
   end

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Regression bench for quadratic_bezier_sampler. Control triples go in over
// the request channel and every sample that comes out is checked against an
// exact integer evaluation of the curve at the current segment count. The
// segment count is rewritten between phases. The extremes 0, 1 and 63 are
// always covered, and random counts make up the rest. The sender works in
// bursts and the receiver stalls on changing patterns.
// ----------------------------------------------------------------------------
module tb;
   import qbs_pkg::*;

   localparam int COORD_BITS = 12;
   localparam logic [COORD_BITS-1:0] COORD_MAX = '1;
   localparam int RANDOM_TRIPLES = 220;
   localparam int SETTLE_CYCLES = 40;
   localparam longint CYCLE_LIMIT = 3_000_000;

   typedef struct packed {
      logic [COORD_BITS-1:0] p0_x;
      logic [COORD_BITS-1:0] p0_y;
      logic [COORD_BITS-1:0] p1_x;
      logic [COORD_BITS-1:0] p1_y;
      logic [COORD_BITS-1:0] p2_x;
      logic [COORD_BITS-1:0] p2_y;
   } triple_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic                  last;
   } sample_type;

   typedef enum {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_SPARSE} stall_mode_type;

   class sample_scoreboard;
      logic [SEG_BITS-1:0] seg_count;
      sample_type expected_samples[$];
      int mismatches;
      int triples;
      int samples;

      function new();
         seg_count = SEG_RESET;
         mismatches = 0;
         triples = 0;
         samples = 0;
      endfunction

      function void set_segments(logic [SEG_BITS-1:0] n);
         seg_count = n;
      endfunction

      // floor(((n-k)^2*a + 2(n-k)k*b + k^2*c) / n^2)
      function logic [COORD_BITS-1:0] floor_axis(logic [COORD_BITS-1:0] a,
                                                 logic [COORD_BITS-1:0] b,
                                                 logic [COORD_BITS-1:0] c,
                                                 longint unsigned n,
                                                 longint unsigned k);
         longint unsigned r;
         longint unsigned num;
         r = n - k;
         num = r * r * a + 2 * r * k * b + k * k * c;
         return COORD_BITS'(num / (n * n));
      endfunction

      function void note_triple(triple_type t);
         longint unsigned n;
         sample_type s;
         n = (seg_count == 0) ? 1 : seg_count;
         for (longint unsigned k = 0; k <= n; k++) begin
            s.x = floor_axis(t.p0_x, t.p1_x, t.p2_x, n, k);
            s.y = floor_axis(t.p0_y, t.p1_y, t.p2_y, n, k);
            s.last = (k == n);
            expected_samples = {expected_samples, s};
         end
         triples++;
      endfunction

      function void check_sample(sample_type got);
         sample_type want;
         samples++;
         if (expected_samples.size() == 0) begin
            $error("unexpected sample: x %0d y %0d last %0d", got.x, got.y, got.last);
            mismatches++;
            return;
         end
         want = expected_samples.pop_front();
         if (got.x !== want.x) begin
            $error("sample_x: expected %0d, actual %0d", want.x, got.x);
            mismatches++;
         end
         if (got.y !== want.y) begin
            $error("sample_y: expected %0d, actual %0d", want.y, got.y);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $error("last_sample: expected %0d, actual %0d", want.last, got.last);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_samples.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   qbs_req_if #(.COORD_BITS(COORD_BITS)) req_ch ();
   qbs_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_ch ();
   qbs_csr_if csr_ch ();

   quadratic_bezier_sampler #(.COORD_BITS(COORD_BITS)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   sample_scoreboard sb;
   longint cycle_count = 0;
   int burst_left = 0;
   int stall_window = 0;
   stall_mode_type stall_mode = STALL_NONE;
   logic [63:0] counts_used = '0;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("quadratic_bezier_sampler regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready)
            sb.set_segments(csr_ch.segment_count);
         if (req_ch.valid && req_ch.ready) begin
            counts_used[sb.seg_count] = 1'b1;
            sb.note_triple('{req_ch.p0_x, req_ch.p0_y, req_ch.p1_x,
                             req_ch.p1_y, req_ch.p2_x, req_ch.p2_y});
         end
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_sample('{rsp_ch.sample_x, rsp_ch.sample_y, rsp_ch.last_sample});
      end
   end

   // receiver stall pattern, switched to a random mode when each random window runs out
   always @(negedge clock) begin
      if (stall_window == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_window = $urandom_range(50, 400);
      end
      stall_window--;
      case (stall_mode)
         STALL_NONE:     rsp_ch.ready = 1'b1;
         STALL_COIN:     rsp_ch.ready = ($urandom_range(0, 1) == 1);
         STALL_PERIODIC: rsp_ch.ready = (stall_window % 5) != 0;
         default:        rsp_ch.ready = $urandom_range(0, 9) > 2;
      endcase
   end

   function automatic logic [COORD_BITS-1:0] rand_coord();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return COORD_MAX;
         default: return COORD_BITS'($urandom_range(0, COORD_MAX));
      endcase
   endfunction

   function automatic triple_type random_triple();
      triple_type t;
      t.p0_x = rand_coord();
      t.p0_y = rand_coord();
      t.p1_x = rand_coord();
      t.p1_y = rand_coord();
      t.p2_x = rand_coord();
      t.p2_y = rand_coord();
      return t;
   endfunction

   // all driving tasks are entered and left just after a falling edge
   task automatic send_triple(triple_type t);
      if (burst_left == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 25)) @(negedge clock);
         burst_left = $urandom_range(1, 8);
      end
      req_ch.p0_x = t.p0_x;
      req_ch.p0_y = t.p0_y;
      req_ch.p1_x = t.p1_x;
      req_ch.p1_y = t.p1_y;
      req_ch.p2_x = t.p2_x;
      req_ch.p2_y = t.p2_y;
      req_ch.valid = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      burst_left--;
   endtask

   task automatic wait_drained();
      req_ch.valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_segments(logic [SEG_BITS-1:0] n);
      csr_ch.segment_count = n;
      csr_ch.valid = 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   initial begin
      int random_sent;
      int phase_len;
      logic [SEG_BITS-1:0] n;
      sb = new();
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.p0_x = '0;
      req_ch.p0_y = '0;
      req_ch.p1_x = '0;
      req_ch.p1_y = '0;
      req_ch.p2_x = '0;
      req_ch.p2_y = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.segment_count = '0;
      random_sent = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // segment count at its reset value
      send_triple('{0, 0, 0, 0, 0, 0});
      send_triple('{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX});
      send_triple('{COORD_MAX, COORD_MAX, 0, 0, 0, 0});
      send_triple('{0, 0, COORD_MAX, COORD_MAX, 0, 0});
      send_triple('{0, 0, 0, 0, COORD_MAX, COORD_MAX});
      send_triple('{COORD_MAX, 0, 0, COORD_MAX, COORD_MAX, 0});
      send_triple('{'hAAA, 'h555, 'h555, 'hAAA, 'hAAA, 'h555});
      send_triple('{COORD_MAX, COORD_MAX, 0, 0, COORD_MAX, COORD_MAX});
      wait_drained();

      // zero count behaves as one segment
      write_segments(SEG_BITS'(0));
      send_triple('{0, COORD_MAX, COORD_MAX, 0, COORD_MAX, 0});
      send_triple('{'h555, 'hAAA, 'hAAA, 'h555, 'h123, 'hFED});
      wait_drained();

      write_segments(SEG_BITS'(63));
      send_triple('{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX});
      send_triple('{0, 0, COORD_MAX, COORD_MAX, 0, 0});
      repeat (4) begin
         send_triple(random_triple());
         random_sent++;
      end
      wait_drained();

      write_segments(SEG_BITS'(1));
      send_triple('{COORD_MAX, 0, 0, COORD_MAX, 0, COORD_MAX});

      while (random_sent < RANDOM_TRIPLES) begin
         wait_drained();
         if ($urandom_range(0, 4) == 0) begin
            n = SEG_BITS'($urandom_range(0, 63));
            phase_len = $urandom_range(2, 5);
         end else begin
            n = SEG_BITS'($urandom_range(0, 12));
            phase_len = $urandom_range(15, 35);
         end
         write_segments(n);
         for (int i = 0; i < phase_len && random_sent < RANDOM_TRIPLES; i++) begin
            if (random_sent == 40 || $urandom_range(0, 24) == 0)
               wait_drained();
            send_triple(random_triple());
            random_sent++;
         end
      end
      wait_drained();

      $display("%0d control triples, %0d samples checked", sb.triples, sb.samples);
      $display("%0d distinct segment counts exercised, 0, 1 and 63 among them",
               $countones(counts_used));
      if (sb.mismatches == 0) begin
         $display("quadratic_bezier_sampler regression: pass");
      end else begin
         $display("quadratic_bezier_sampler regression: fail");
      end
      $finish;
   end

endmodule
